[hdl/cppw_pkg.sv]
// Package for the compressed phase pattern writer.
// Holds the request, response and job types and the fixed codes.
// No dependencies.
package cppw_pkg;

   // Action codes of a request.
   localparam logic ACTION_HEADER = 1'b0;
   localparam logic ACTION_DATA   = 1'b1;

   // Kind codes of a response.
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_WRITE  = 1'b1;

   // Status codes of a header response.
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   // Phase formats.
   localparam logic [1:0] FORMAT_FULL = 2'd0;
   localparam logic [1:0] FORMAT_HALF = 2'd1;

   // Group limits per format.
   localparam logic [7:0] MAX_GROUPS_FULL = 8'd2;
   localparam logic [7:0] MAX_GROUPS_HALF = 8'd4;

   // Intensity byte placed above every phase.
   localparam logic [7:0] FULL_INTENSITY = 8'hFF;

   // Depth of the job queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic        action;
      logic [7:0]  bank;
      logic [1:0]  format;
      logic [7:0]  group_count;
      logic [15:0] start_offset;
      logic [15:0] packed_word;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic        status;
      logic [7:0]  write_bank;
      logic [15:0] write_address;
      logic [15:0] write_data;
      logic        last;
   } rsp_type;

   // One classified transaction handed from the front to the back.
   typedef struct packed {
      logic        is_write;
      logic        status;
      logic        half;
      logic [2:0]  groups;
      logic [7:0]  bank;
      logic [15:0] base;
      logic [15:0] word;
   } job_type;

endpackage

[hdl/compressed_phase_pattern_writer.sv]
// A header transaction is checked and answered with one status response; each
// later data word after a good header, up to TRANSDUCERS words, fans out into
// group_count pattern memory writes (one to four), ordered by transducer and then
// by ascending group. The front end takes one transaction per cycle while its
// two-entry job queue has room; the back end issues one response per cycle,
// while the output is empty or popped, from a single output register, which a
// header fills once and a data word group_count times; this sets the sustained rate.
// Depends on cppw_pkg, cppw_front, cppw_queue and cppw_back.
module compressed_phase_pattern_writer #(
   parameter int TRANSDUCERS = 256,
   parameter int BANKS       = 2,
   parameter int RAM_WORDS   = 65536,
   parameter int SLOT_WORDS  = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  cppw_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output cppw_pkg::rsp_type rsp_data
);
   import cppw_pkg::*;

   logic    job_push, job_full, job_pop, job_valid;
   job_type job_in_data, job_out_data;

   cppw_front #(
      .TRANSDUCERS (TRANSDUCERS),
      .BANKS       (BANKS),
      .RAM_WORDS   (RAM_WORDS),
      .SLOT_WORDS  (SLOT_WORDS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .job_push (job_push),
      .job_data (job_in_data),
      .job_full (job_full)
   );

   cppw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out_data),
      .valid     (job_valid)
   );

   cppw_back #(
      .SLOT_WORDS (SLOT_WORDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (job_out_data),
      .job_pop   (job_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

[hdl/cppw_front.sv]
// Front end: accepts requests, validates headers, holds the header state.
// Emits one job per header and per data word after a good header, up to TRANSDUCERS. Uses cppw_pkg.
module cppw_front #(
   parameter int TRANSDUCERS = 256,
   parameter int BANKS       = 2,
   parameter int RAM_WORDS   = 65536,
   parameter int SLOT_WORDS  = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  cppw_pkg::req_type req_data,
   output logic              job_push,
   output cppw_pkg::job_type job_data,
   input  logic              job_full
);
   import cppw_pkg::*;

   localparam int IDX_W = $clog2(TRANSDUCERS + 1);
   localparam logic [31:0] BANKS_W = 32'(BANKS);
   localparam logic [31:0] RAM_W   = 32'(RAM_WORDS);
   localparam logic [31:0] SLOT_W  = 32'(SLOT_WORDS);
   localparam logic [31:0] XDCR_W  = 32'(TRANSDUCERS);
   localparam logic [IDX_W-1:0] IDX_END = IDX_W'(TRANSDUCERS);

   logic             valid_ff, valid_in;
   logic [7:0]       bank_ff, bank_in;
   logic             half_ff, half_in;
   logic [2:0]       groups_ff, groups_in;
   logic [15:0]      offset_ff, offset_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic        accept;
   logic        bad;
   logic [7:0]  count_cap;
   logic [1:0]  count_m1;
   logic [31:0] span;
   logic [31:0] room;

   assign full   = job_full;
   assign accept = push && !job_full;

   always_comb begin
      count_cap = (req_data.format == FORMAT_FULL) ? MAX_GROUPS_FULL : MAX_GROUPS_HALF;
      count_m1  = 2'(req_data.group_count - 8'd1);
      span      = 32'(count_m1) * SLOT_W + XDCR_W;
      room      = RAM_W - 32'(req_data.start_offset);
      bad = 1'b0;
      if (32'(req_data.bank) >= BANKS_W) bad = 1'b1;
      if (req_data.format != FORMAT_FULL && req_data.format != FORMAT_HALF) bad = 1'b1;
      if (req_data.group_count == 8'd0 || req_data.group_count > count_cap) bad = 1'b1;
      if (32'(req_data.start_offset) > RAM_W) bad = 1'b1;
      // The span check only counts once the count is known to be in range.
      if (!bad && span > room) bad = 1'b1;
   end

   always_comb begin
      valid_in  = valid_ff;
      bank_in   = bank_ff;
      half_in   = half_ff;
      groups_in = groups_ff;
      offset_in = offset_ff;
      idx_in    = idx_ff;
      job_push  = 1'b0;

      job_data          = '0;
      job_data.bank     = bank_ff;
      job_data.half     = half_ff;
      job_data.groups   = groups_ff;
      job_data.base     = offset_ff + 16'(idx_ff);
      job_data.word     = req_data.packed_word;
      job_data.is_write = KIND_WRITE;

      if (accept) begin
         if (req_data.action == ACTION_HEADER) begin
            job_push          = 1'b1;
            job_data          = '0;
            job_data.is_write = KIND_STATUS;
            job_data.groups   = 3'd1;
            if (bad) begin
               job_data.status = STATUS_BAD;
               valid_in        = 1'b0;
            end else begin
               job_data.status = STATUS_OK;
               valid_in        = 1'b1;
               bank_in         = req_data.bank;
               half_in         = (req_data.format == FORMAT_HALF);
               groups_in       = req_data.group_count[2:0];
               offset_in       = req_data.start_offset;
               idx_in          = '0;
            end
         end else if (valid_ff && idx_ff < IDX_END) begin
            job_push = 1'b1;
            idx_in   = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         bank_ff   <= '0;
         half_ff   <= 1'b0;
         groups_ff <= '0;
         offset_ff <= '0;
         idx_ff    <= '0;
      end else begin
         valid_ff  <= valid_in;
         bank_ff   <= bank_in;
         half_ff   <= half_in;
         groups_ff <= groups_in;
         offset_ff <= offset_in;
         idx_ff    <= idx_in;
      end
   end

endmodule

[hdl/cppw_queue.sv]
// Short job queue between the front and the back end.
// Depth comes from cppw_pkg::QUEUE_DEPTH. Uses cppw_pkg.
module cppw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cppw_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output cppw_pkg::job_type pop_data,
   output logic              valid
);
   import cppw_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);

   job_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == DEPTH_C);
   assign valid    = (cnt_ff != '0);
   assign pop_data = slot_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PTR_W'(1);
      if (do_pop)  rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PTR_W'(1);
      if (do_push && !do_pop)      cnt_in = cnt_ff + CNT_W'(1);
      else if (do_pop && !do_push) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[hdl/cppw_back.sv]
// Back end: expands each job into its responses, one per cycle unless the output stalls.
// Drives the response register seen on the output ports. Uses cppw_pkg.
module cppw_back #(
   parameter int SLOT_WORDS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  cppw_pkg::job_type job_data,
   output logic              job_pop,
   output logic              empty,
   input  logic              pop,
   output cppw_pkg::rsp_type rsp_data
);
   import cppw_pkg::*;

   localparam logic [31:0] SLOT_W = 32'(SLOT_WORDS);

   logic    busy_ff, busy_in;
   job_type job_ff, job_in;
   logic [1:0] grp_ff, grp_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;

   rsp_type    cur;
   logic [2:0] cur_count;
   logic       cur_last;
   logic       advance;
   logic [7:0] phase;
   logic [3:0] nibble;

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;
   assign advance  = !out_valid_ff || pop;

   always_comb begin
      unique case (grp_ff)
         2'd0:    nibble = job_ff.word[3:0];
         2'd1:    nibble = job_ff.word[7:4];
         2'd2:    nibble = job_ff.word[11:8];
         default: nibble = job_ff.word[15:12];
      endcase
      if (job_ff.half) phase = {nibble, nibble};
      else             phase = grp_ff[0] ? job_ff.word[15:8] : job_ff.word[7:0];

      cur_count = (job_ff.is_write == KIND_WRITE) ? job_ff.groups : 3'd1;
      cur_last  = (3'(grp_ff) + 3'd1 == cur_count);

      cur      = '0;
      cur.kind = job_ff.is_write;
      cur.last = cur_last;
      if (job_ff.is_write == KIND_WRITE) begin
         cur.status        = STATUS_OK;
         cur.write_bank    = job_ff.bank;
         cur.write_address = job_ff.base + 16'(32'(grp_ff) * SLOT_W);
         cur.write_data    = {FULL_INTENSITY, phase};
      end else begin
         cur.status = job_ff.status;
      end
   end

   // A new job is taken when idle or as the current one issues its last response.
   assign job_pop = job_valid && (!busy_ff || (advance && cur_last));

   always_comb begin
      busy_in      = busy_ff;
      job_in       = job_ff;
      grp_in       = grp_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (busy_ff && advance) begin
         out_in       = cur;
         out_valid_in = 1'b1;
         grp_in       = grp_ff + 2'd1;
         if (cur_last) busy_in = 1'b0;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
      if (job_pop) begin
         job_in  = job_data;
         busy_in = 1'b1;
         grp_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         grp_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         grp_ff       <= grp_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

[hdl/cppw_checker.sv]
// Port-level checks for the compressed phase pattern writer.
// Bound to the top level below. Uses cppw_pkg.
module cppw_checker (
   input logic              clock,
   input logic              reset,
   input logic              full,
   input logic              empty,
   input logic              pop,
   input cppw_pkg::rsp_type rsp_data
);
   import cppw_pkg::*;

   // Nothing is pending and there is room right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("block not idle after reset");

   // A header answer is always the only response of its transaction.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.kind == KIND_STATUS) |-> rsp_data.last)
      else $error("status response without last");

   // Memory writes carry full intensity and an OK status.
   a_write_form: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.kind == KIND_WRITE) |->
         (rsp_data.write_data[15:8] == FULL_INTENSITY && rsp_data.status == STATUS_OK))
      else $error("malformed memory write response");

   // A waiting response holds until it is popped.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("response changed while stalled");

endmodule

bind compressed_phase_pattern_writer cppw_checker u_cppw_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);

[sim/compressed_phase_pattern_writer_tb.sv]
`timescale 1ns / 100ps
// Testbench for compressed_phase_pattern_writer: directed and random header and data
// transactions, with every response checked against a built-in write prediction.
// Depends on cppw_pkg and the RTL of the block.
module compressed_phase_pattern_writer_tb;
   import cppw_pkg::*;

   localparam int TRANSDUCERS  = 256;
   localparam int BANKS        = 2;
   localparam int RAM_WORDS    = 65536;
   localparam int SLOT_WORDS   = 256;
   localparam int RANDOM_ITEMS = 120;

   // Format codes that the block must reject.
   localparam logic [1:0] FORMAT_BAD_LOW  = 2'd2;
   localparam logic [1:0] FORMAT_BAD_HIGH = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    pop = 1'b0;
   logic    full;
   logic    empty;
   req_type req_data = '0;
   rsp_type rsp_data;

   req_type request_backlog[$];
   rsp_type owed_responses[$];

   // Predicted state of the writer.
   logic        pattern_armed = 1'b0;
   logic [7:0]  armed_bank = '0;
   logic        armed_half = 1'b0;
   logic [2:0]  armed_groups = '0;
   logic [15:0] armed_offset = '0;
   logic [8:0]  next_transducer = '0;

   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   int   send_gap = 0;
   int   quiet_sends = 0;
   int   pop_stall = 0;
   int   quiet_pops = 0;
   int   fault_count = 0;

   compressed_phase_pattern_writer #(
      .TRANSDUCERS(TRANSDUCERS),
      .BANKS(BANKS),
      .RAM_WORDS(RAM_WORDS),
      .SLOT_WORDS(SLOT_WORDS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data(req_data),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type header_item(int bank, int fmt, int count, int offset);
      req_type r;
      r.action       = ACTION_HEADER;
      r.bank         = 8'(bank);
      r.format       = 2'(fmt);
      r.group_count  = 8'(count);
      r.start_offset = 16'(offset);
      r.packed_word  = 16'($urandom);
      return r;
   endfunction

   function automatic req_type data_item(logic [15:0] word);
      req_type r;
      r.action       = ACTION_DATA;
      r.bank         = 8'($urandom);
      r.format       = 2'($urandom);
      r.group_count  = 8'($urandom);
      r.start_offset = 16'($urandom);
      r.packed_word  = word;
      return r;
   endfunction

   // A header that passes every check, sometimes placed at the highest legal offset.
   function automatic req_type valid_header();
      int half;
      int count;
      int ceiling;
      int offset;
      half = $urandom_range(0, 1);
      count = $urandom_range(1, half ? MAX_GROUPS_HALF : MAX_GROUPS_FULL);
      ceiling = RAM_WORDS - (count - 1) * SLOT_WORDS - TRANSDUCERS;
      offset = ($urandom_range(0, 9) == 0) ? ceiling : $urandom_range(0, ceiling);
      return header_item($urandom_range(0, BANKS - 1), half ? FORMAT_HALF : FORMAT_FULL,
                         count, offset);
   endfunction

   // Works out the responses that one accepted transaction must produce.
   task automatic expand_request(input req_type r);
      logic        reject;
      int          group_limit;
      logic [7:0]  phase;
      rsp_type     w;
      if (r.action == ACTION_HEADER) begin
         group_limit = (r.format == FORMAT_FULL) ? MAX_GROUPS_FULL : MAX_GROUPS_HALF;
         reject = (r.bank >= BANKS) || (r.format > FORMAT_HALF) || (r.group_count == 0)
                  || (r.group_count > group_limit) || (r.start_offset > RAM_WORDS);
         if (!reject && (int'(r.group_count) - 1) * SLOT_WORDS + TRANSDUCERS
                        > RAM_WORDS - int'(r.start_offset))
            reject = 1'b1;
         w = '0;
         w.kind   = KIND_STATUS;
         w.status = reject ? STATUS_BAD : STATUS_OK;
         w.last   = 1'b1;
         owed_responses.push_back(w);
         pattern_armed = !reject;
         if (!reject) begin
            armed_bank      = r.bank;
            armed_half      = (r.format == FORMAT_HALF);
            armed_groups    = 3'(r.group_count);
            armed_offset    = r.start_offset;
            next_transducer = '0;
         end
      end else if (pattern_armed && next_transducer < TRANSDUCERS) begin
         for (int g = 0; g < armed_groups; g++) begin
            if (armed_half)
               phase = {2{r.packed_word[4 * g +: 4]}};
            else
               phase = r.packed_word[8 * (g % 2) +: 8];
            w.kind          = KIND_WRITE;
            w.status        = STATUS_OK;
            w.write_bank    = armed_bank;
            w.write_address = 16'(armed_offset + g * SLOT_WORDS + next_transducer);
            w.write_data    = {FULL_INTENSITY, phase};
            w.last          = (g == armed_groups - 1);
            owed_responses.push_back(w);
         end
         next_transducer = next_transducer + 1'b1;
      end
   endtask

   task automatic report_fault(input string why, input rsp_type want);
      fault_count++;
      if (fault_count <= 10) begin
         $write("%0t: %s: expected kind %0d status %0d bank %h addr %h data %h last %0d, ",
                $realtime, why, want.kind, want.status, want.write_bank,
                want.write_address, want.write_data, want.last);
         $display("got kind %0d status %0d bank %h addr %h data %h last %0d",
                  rsp_data.kind, rsp_data.status, rsp_data.write_bank,
                  rsp_data.write_address, rsp_data.write_data, rsp_data.last);
      end
   endtask

   // Monitor: checks each popped response, then predicts from each pushed request.
   always @(posedge clock) begin
      rsp_type want;
      req_fire <= push && !full;
      rsp_fire <= pop && !empty;
      if (!reset) begin
         if (pop && !empty) begin
            if (owed_responses.size() == 0) begin
               report_fault("response with nothing outstanding", '0);
            end else begin
               want = owed_responses.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.status !== want.status
                   || rsp_data.write_bank !== want.write_bank
                   || rsp_data.write_address !== want.write_address
                   || rsp_data.write_data !== want.write_data
                   || rsp_data.last !== want.last)
                  report_fault("response mismatch", want);
            end
         end
         if (push && !full)
            expand_request(req_data);
      end
   end

   // Request driver: holds an item until it is taken, then sometimes idles for a while.
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!push || req_fire) begin
         if (send_gap > 0) begin
            push <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (request_backlog.size() > 0) begin
            push <= 1'b1;
            req_data <= request_backlog.pop_front();
            if (quiet_sends > 0) begin
               quiet_sends <= quiet_sends - 1;
            end else begin
               send_gap <= idle_span();
               if ($urandom_range(0, 24) == 0)
                  quiet_sends <= $urandom_range(10, 40);
            end
         end else begin
            push <= 1'b0;
         end
      end
   end

   // Response side: pop stays high except during random stalls.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (pop_stall > 0) begin
         pop <= 1'b0;
         pop_stall <= pop_stall - 1;
      end else if (rsp_fire && quiet_pops == 0 && $urandom_range(0, 2) == 0) begin
         pop <= 1'b0;
         pop_stall <= idle_span();
      end else begin
         pop <= 1'b1;
         if (rsp_fire && quiet_pops > 0)
            quiet_pops <= quiet_pops - 1;
         else if (quiet_pops == 0 && $urandom_range(0, 40) == 0)
            quiet_pops <= $urandom_range(10, 40);
      end
   end

   task automatic wait_drained();
      while (request_backlog.size() != 0 || push || owed_responses.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int made;
      int pick;
      int run;

      // Data before any header, then every way a header can be rejected.
      request_backlog.push_back(data_item(16'hFFFF));
      request_backlog.push_back(header_item(BANKS, FORMAT_FULL, 1, 0));
      request_backlog.push_back(header_item(255, FORMAT_FULL, 1, 0));
      request_backlog.push_back(header_item(0, FORMAT_BAD_LOW, 1, 0));
      request_backlog.push_back(header_item(1, FORMAT_BAD_HIGH, 2, 0));
      request_backlog.push_back(header_item(0, FORMAT_FULL, 0, 0));
      request_backlog.push_back(header_item(0, FORMAT_FULL, 3, 0));
      request_backlog.push_back(header_item(0, FORMAT_HALF, 5, 0));
      request_backlog.push_back(header_item(1, FORMAT_HALF, 255, 0));
      request_backlog.push_back(data_item(16'h1234));
      request_backlog.push_back(header_item(0, FORMAT_FULL, 2, 65025));
      request_backlog.push_back(header_item(0, FORMAT_HALF, 4, 64513));
      request_backlog.push_back(header_item(1, FORMAT_FULL, 1, 65535));
      // Accepted headers at the edges of memory, with extreme data words.
      request_backlog.push_back(header_item(0, FORMAT_HALF, 1, 65280));
      request_backlog.push_back(data_item(16'hFFFF));
      request_backlog.push_back(header_item(1, FORMAT_FULL, 2, 65024));
      request_backlog.push_back(data_item(16'h0000));
      request_backlog.push_back(data_item(16'hFFFF));
      request_backlog.push_back(data_item(16'hA55A));
      request_backlog.push_back(header_item(0, FORMAT_HALF, 4, 64512));
      request_backlog.push_back(data_item(16'h0000));
      request_backlog.push_back(data_item(16'hFFFF));
      request_backlog.push_back(data_item(16'h1234));
      request_backlog.push_back(header_item(1, FORMAT_HALF, 3, 0));
      request_backlog.push_back(data_item(16'h8421));
      request_backlog.push_back(header_item(0, FORMAT_FULL, 1, 0));
      request_backlog.push_back(data_item(16'h00FF));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The sender holds off here until the block has answered everything.
      wait_drained();

      // Mostly well-formed patterns, with some rejected headers and stray words.
      made = 0;
      while (made < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            request_backlog.push_back(valid_header());
            run = $urandom_range(1, 10);
            repeat (run)
               request_backlog.push_back(data_item(16'($urandom)));
            made += run + 1;
         end else if (pick < 88) begin
            request_backlog.push_back(header_item($urandom_range(0, 255),
                                                  $urandom_range(0, 3),
                                                  $urandom_range(0, 255),
                                                  $urandom_range(0, 65535)));
            run = $urandom_range(0, 2);
            repeat (run)
               request_backlog.push_back(data_item(16'($urandom)));
            made += run + 1;
         end else begin
            request_backlog.push_back(data_item(16'($urandom)));
            made++;
         end
      end
      wait_drained();

      repeat (20) @(posedge clock);
      if (fault_count == 0 && owed_responses.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
